[rtl/rumf_pkg.sv]
package rumf_pkg;

  localparam int MAX_DIM  = 4;
  localparam int PAT_W    = MAX_DIM * MAX_DIM;
  localparam int DIM_W    = 3;
  localparam int CNT_W    = 15;
  localparam int IDX_W    = 14;
  localparam int EPOCH_W  = 8;
  localparam int NUM_ROT  = 4;

  localparam logic [CNT_W-1:0]   COUNT_LIMIT = CNT_W'(16384);
  localparam logic [IDX_W-1:0]   INDEX_MAX   = {IDX_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [DIM_W-1:0]   DIM_RESET   = DIM_W'(MAX_DIM);

  typedef enum logic [1:0] {
    VERDICT_ACCEPT  = 2'd0,
    VERDICT_SYMM    = 2'd1,
    VERDICT_COVERED = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_WRITE,
    S_DONE
  } back_state_t;

  // one classified item on its way from front to back
  typedef struct packed {
    logic [NUM_ROT-1:0][PAT_W-1:0] rot;
    logic                          distinct;
    logic                          start_new;
  } job_t;

  function automatic logic [DIM_W-1:0] effective_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) r = DIM_W'(1);
    else if (d > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    else r = d;
    return r;
  endfunction

  function automatic logic [PAT_W-1:0] dim_mask(input logic [DIM_W-1:0] d);
    logic [PAT_W-1:0] m;
    case (d)
      3'd1:    m = PAT_W'(16'h0001);
      3'd2:    m = PAT_W'(16'h000F);
      3'd3:    m = PAT_W'(16'h01FF);
      default: m = {PAT_W{1'b1}};
    endcase
    return m;
  endfunction

  // clockwise quarter turn for a fixed side: new(i,j) = old(dd-1-j, i)
  function automatic logic [PAT_W-1:0] turn_fixed(input logic [PAT_W-1:0] p,
                                                  input int dd);
    logic [PAT_W-1:0] r;
    logic [3:0]       src;
    logic [3:0]       dst;
    r = '0;
    for (int i = 0; i < MAX_DIM; i++) begin
      for (int j = 0; j < MAX_DIM; j++) begin
        if (i < dd && j < dd) begin
          src    = 4'((dd - 1 - j) * dd + i);
          dst    = 4'(i * dd + j);
          r[dst] = p[src];
        end
      end
    end
    return r;
  endfunction

  function automatic logic [PAT_W-1:0] turn_quarter(input logic [PAT_W-1:0] p,
                                                    input logic [DIM_W-1:0] d);
    logic [PAT_W-1:0] r;
    case (d)
      3'd1:    r = turn_fixed(p, 1);
      3'd2:    r = turn_fixed(p, 2);
      3'd3:    r = turn_fixed(p, 3);
      default: r = turn_fixed(p, 4);
    endcase
    return r;
  endfunction

endpackage

[rtl/rumf_front.sv]
module rumf_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rumf_pkg::DIM_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rumf_pkg::PAT_W-1:0]  pattern_bits,
  input  logic                        start_new,
  output logic                        job_valid,
  input  logic                        job_ready,
  output rumf_pkg::job_t              job
);

  logic [rumf_pkg::DIM_W-1:0] grid_dim;
  logic [rumf_pkg::DIM_W-1:0] dim;
  logic [rumf_pkg::NUM_ROT-1:0][rumf_pkg::PAT_W-1:0] rot;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_dim <= rumf_pkg::DIM_RESET;
    end else if (cfg_we) begin
      grid_dim <= cfg_wdata;
    end
  end

  always_comb begin
    dim    = rumf_pkg::effective_dim(grid_dim);
    rot[0] = pattern_bits & rumf_pkg::dim_mask(dim);
    rot[1] = rumf_pkg::turn_quarter(rot[0], dim);
    rot[2] = rumf_pkg::turn_quarter(rot[1], dim);
    rot[3] = rumf_pkg::turn_quarter(rot[2], dim);
  end

  assign job.rot       = rot;
  assign job.distinct  = (rot[0] != rot[1]) && (rot[0] != rot[2]) && (rot[0] != rot[3]) &&
                         (rot[1] != rot[2]) && (rot[1] != rot[3]) && (rot[2] != rot[3]);
  assign job.start_new = start_new;
  assign job_valid     = in_valid;
  assign in_ready      = job_ready;

endmodule

[rtl/rumf_queue.sv]
module rumf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  rumf_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rumf_pkg::job_t pop_job
);

  rumf_pkg::job_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic           push;
  logic           pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_job    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

endmodule

[rtl/rumf_back.sv]
module rumf_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        job_valid,
  output logic                        job_ready,
  input  rumf_pkg::job_t              job,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        accepted,
  output logic [1:0]                  verdict,
  output logic [rumf_pkg::IDX_W-1:0]  entry_index,
  output logic [rumf_pkg::CNT_W-1:0]  entry_count
);

  // map entries hold the epoch in which they were marked
  logic [rumf_pkg::EPOCH_W-1:0] map_mem [2**rumf_pkg::PAT_W];

  rumf_pkg::back_state_t state, state_next;
  rumf_pkg::job_t        cur;
  rumf_pkg::verdict_t    res_verdict, chk_verdict;
  logic [rumf_pkg::IDX_W-1:0]   res_index;
  logic [rumf_pkg::CNT_W-1:0]   count;
  logic [rumf_pkg::EPOCH_W-1:0] epoch;
  logic [rumf_pkg::EPOCH_W-1:0] rd_data;
  logic [rumf_pkg::PAT_W-1:0]   clr_addr;
  logic [1:0]                   wr_idx;
  logic                         resume;
  logic                         mem_we;
  logic [rumf_pkg::PAT_W-1:0]   mem_waddr;
  logic [rumf_pkg::EPOCH_W-1:0] mem_wdata;
  logic                         out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rumf_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    job_ready   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = clr_addr;
    mem_wdata   = '0;
    chk_verdict = rumf_pkg::VERDICT_ACCEPT;
    if (!cur.distinct) chk_verdict = rumf_pkg::VERDICT_SYMM;
    else if (rd_data == epoch || count >= rumf_pkg::COUNT_LIMIT)
      chk_verdict = rumf_pkg::VERDICT_COVERED;
    case (state)
      rumf_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == {rumf_pkg::PAT_W{1'b1}}) begin
          state_next = resume ? rumf_pkg::S_READ : rumf_pkg::S_IDLE;
        end
      end
      rumf_pkg::S_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          if (job.start_new && epoch == rumf_pkg::EPOCH_MAX) state_next = rumf_pkg::S_CLEAR;
          else state_next = rumf_pkg::S_READ;
        end
      end
      rumf_pkg::S_READ:  state_next = rumf_pkg::S_CHECK;
      rumf_pkg::S_CHECK: begin
        state_next = (chk_verdict == rumf_pkg::VERDICT_ACCEPT) ? rumf_pkg::S_WRITE
                                                               : rumf_pkg::S_DONE;
      end
      rumf_pkg::S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = cur.rot[wr_idx];
        mem_wdata = epoch;
        if (wr_idx == 2'd3) state_next = rumf_pkg::S_DONE;
      end
      rumf_pkg::S_DONE: begin
        if (out_free) state_next = rumf_pkg::S_IDLE;
      end
      default: state_next = rumf_pkg::S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      epoch     <= rumf_pkg::EPOCH_FIRST;
      clr_addr  <= '0;
      resume    <= 1'b0;
      wr_idx    <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (state == rumf_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        rumf_pkg::S_CLEAR: clr_addr <= clr_addr + rumf_pkg::PAT_W'(1);
        rumf_pkg::S_IDLE: begin
          if (job_valid) begin
            resume <= job.start_new && epoch == rumf_pkg::EPOCH_MAX;
            if (job.start_new) begin
              count <= '0;
              if (epoch == rumf_pkg::EPOCH_MAX) begin
                // tags would alias: sweep the map and restart the epochs
                epoch    <= rumf_pkg::EPOCH_FIRST;
                clr_addr <= '0;
              end else begin
                epoch <= epoch + rumf_pkg::EPOCH_W'(1);
              end
            end
          end
        end
        rumf_pkg::S_CHECK: begin
          wr_idx <= 2'd0;
          if (chk_verdict == rumf_pkg::VERDICT_ACCEPT) count <= count + rumf_pkg::CNT_W'(1);
        end
        rumf_pkg::S_WRITE: wr_idx <= wr_idx + 2'd1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == rumf_pkg::S_IDLE && job_valid) cur <= job;
    if (state == rumf_pkg::S_CHECK) begin
      res_verdict <= chk_verdict;
      res_index   <= (count >= rumf_pkg::COUNT_LIMIT) ? rumf_pkg::INDEX_MAX
                                                      : count[rumf_pkg::IDX_W-1:0];
    end
    if (state == rumf_pkg::S_DONE && out_free) begin
      accepted    <= (res_verdict == rumf_pkg::VERDICT_ACCEPT);
      verdict     <= res_verdict;
      entry_index <= res_index;
      entry_count <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) map_mem[mem_waddr] <= mem_wdata;
    rd_data <= map_mem[cur.rot[0]];
  end

endmodule

[rtl/rotation_unique_marker_filter.sv]
// Each item is read from the visited map, checked and reported; an accepted item also
//   writes the map once per rotation before it is reported. The map sequencer takes the
//   next item only once it is through with the last.
// A two-item queue between classifier and map sequencer lets each side stall alone.
// Reset: synchronous, active high; a clearing pass over every map entry follows reset and
//   every 255th start_new, during which only the two-item queue takes items.
module rotation_unique_marker_filter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rumf_pkg::DIM_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rumf_pkg::PAT_W-1:0]  pattern_bits,
  input  logic                        start_new,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        accepted,
  output logic [1:0]                  verdict,
  output logic [rumf_pkg::IDX_W-1:0]  entry_index,
  output logic [rumf_pkg::CNT_W-1:0]  entry_count
);

  rumf_pkg::job_t front_job, back_job;
  logic front_valid, front_ready;
  logic back_valid, back_ready;

  rumf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pattern_bits (pattern_bits),
    .start_new    (start_new),
    .job_valid    (front_valid),
    .job_ready    (front_ready),
    .job          (front_job)
  );

  rumf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_job   (front_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_job    (back_job)
  );

  rumf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (back_valid),
    .job_ready   (back_ready),
    .job         (back_job),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .accepted    (accepted),
    .verdict     (verdict),
    .entry_index (entry_index),
    .entry_count (entry_count)
  );

endmodule

[rtl/rumf_checker.sv]
module rumf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        accepted,
  input logic [1:0]                  verdict,
  input logic [rumf_pkg::IDX_W-1:0]  entry_index,
  input logic [rumf_pkg::CNT_W-1:0]  entry_count
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(entry_count) && $stable(verdict))
    else $error("result changed while stalled");

  a_flag_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> accepted == (verdict == rumf_pkg::VERDICT_ACCEPT))
    else $error("accepted flag disagrees with verdict");

  a_accept_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> entry_count == {1'b0, entry_index} + rumf_pkg::CNT_W'(1))
    else $error("accepted item count is not index plus one");

  a_reject_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |->
      (entry_count == {1'b0, entry_index}) ||
      (entry_count == rumf_pkg::COUNT_LIMIT && entry_index == rumf_pkg::INDEX_MAX))
    else $error("rejected item index does not follow the count");

endmodule

bind rotation_unique_marker_filter rumf_checker u_rumf_checker (.*);
